// File: rtl/core/rfa_pkg.sv
// Shared constants and types for the rational fraction ALU.
// No dependencies; every other file of the block refers to it by scoped name.
package rfa_pkg;

  localparam int OP_W  = 2;
  localparam int RES_W = 48;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DIV = 2'd1;
  localparam logic [OP_W-1:0] OP_RED = 2'd2;

  // divider request / response flags
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/rfa_req_if.sv
// Request channel of the rational fraction ALU: opcode and two fractions.
// Depends on rfa_pkg.
interface rfa_req_if #(
  parameter int W = 16
);
  logic                      valid;
  logic                      ready;
  logic [rfa_pkg::OP_W-1:0]  op;
  logic signed [W-1:0]       a_num;
  logic signed [W-1:0]       a_den;
  logic signed [W-1:0]       b_num;
  logic signed [W-1:0]       b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

// File: rtl/core/rfa_rsp_if.sv
// Response channel of the rational fraction ALU: result fraction and status.
// Depends on rfa_pkg.
interface rfa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [rfa_pkg::RES_W-1:0] res_num;
  logic signed [rfa_pkg::RES_W-1:0] res_den;
  logic                             status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// File: rtl/core/rational_fraction_alu.sv
// Rational fraction ALU: add (unreduced, over the lcm), divide (reduced), reduce.
// Depends on rfa_pkg, rfa_req_if, rfa_rsp_if and rfa_div.
//
// One request is worked at a time; ready is high only while the sequencer is
// idle, and a finished result may wait in the output register while the next
// request is accepted. Time per request is set by the bit-serial divider of
// DW = 2*OPERAND_WIDTH+2 bits (34 at the default), which every division
// step shares. Euclid's loop spends one division per remainder step, then
// two more divide the operands by the gcd. Divide first forms the cross
// products on the shared multiplier, and add then forms the scaled
// numerators and the lcm on it. Requests that fail a zero check at entry
// go straight to the finish state. A zero divisor or an unused opcode
// gives status 1 and zeros.
module rational_fraction_alu #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  rfa_req_if.sink   req,
  rfa_rsp_if.source rsp
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = W + 1;
  localparam int DW = 2 * MW;
  localparam int RW = rfa_pkg::RES_W;
  localparam int EW = (DW > RW) ? DW : RW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MN    = 4'd1;
  localparam logic [3:0] S_MD    = 4'd2;
  localparam logic [3:0] S_MX    = 4'd3;
  localparam logic [3:0] S_GCD   = 4'd4;
  localparam logic [3:0] S_GCDW  = 4'd5;
  localparam logic [3:0] S_DIVN  = 4'd6;
  localparam logic [3:0] S_DIVNW = 4'd7;
  localparam logic [3:0] S_DIVD  = 4'd8;
  localparam logic [3:0] S_DIVDW = 4'd9;
  localparam logic [3:0] S_T1    = 4'd10;
  localparam logic [3:0] S_T2    = 4'd11;
  localparam logic [3:0] S_T3    = 4'd12;
  localparam logic [3:0] S_T4    = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0]               state;
  logic [rfa_pkg::OP_W-1:0] op_r;
  logic                     err;
  logic signed [W-1:0]      an_r, ad_r, bn_r, bd_r;
  logic signed [DW-1:0]     num_r, den_r;
  logic signed [DW-1:0]     x, y;
  logic signed [DW-1:0]     q1, q2;
  logic signed [DW-1:0]     acc;
  logic signed [DW-1:0]     prod;
  logic signed [DW-1:0]     rn_r, rd_r;
  logic signed [MW-1:0]     ma, mb;
  logic signed [EW-1:0]     rn_ext, rd_ext;
  logic                     out_valid;
  logic                     in_beat;
  logic                     out_beat;

  rfa_pkg::div_ctrl_t   dctrl;
  rfa_pkg::div_stat_t   dstat;
  logic signed [DW-1:0] d_a, d_b, d_q, d_r;

  rfa_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .dividend (d_a),
    .divisor  (d_b),
    .stat     (dstat),
    .quo      (d_q),
    .rem      (d_r)
  );

  assign in_beat  = req.valid && req.ready;
  assign out_beat = rsp.valid && rsp.ready;
  assign req.ready = (state == S_IDLE) && !rst;

  // divider operands; in the divide-by-gcd steps x holds the gcd
  always_comb begin
    dctrl.start = ((state == S_GCD) && (y != '0) && !dstat.busy) ||
                  (state == S_DIVN) || (state == S_DIVD);
    d_a = (state == S_GCD) ? x : ((state == S_DIVN) ? num_r : den_r);
    d_b = (state == S_GCD) ? y : x;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MN:    begin ma = MW'(an_r); mb = MW'(bd_r);     end
      S_MD:    begin ma = MW'(ad_r); mb = MW'(bn_r);     end
      S_T1:    begin ma = MW'(an_r); mb = q2[MW-1:0];    end
      S_T2:    begin ma = MW'(bn_r); mb = q1[MW-1:0];    end
      S_T3:    begin ma = MW'(ad_r); mb = q2[MW-1:0];    end
      default: begin ma = '0;        mb = '0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            op_r <= req.op;
            an_r <= req.a_num;
            ad_r <= req.a_den;
            bn_r <= req.b_num;
            bd_r <= req.b_den;
            err  <= 1'b0;
            priority if (req.op == rfa_pkg::OP_ADD) begin
              if ((req.a_den == '0) || (req.b_den == '0)) begin
                err   <= 1'b1;
                state <= S_FIN;
              end else begin
                num_r <= DW'(req.a_den);
                den_r <= DW'(req.b_den);
                x     <= DW'(req.a_den);
                y     <= DW'(req.b_den);
                state <= S_GCD;
              end
            end else if (req.op == rfa_pkg::OP_DIV) begin
              if (req.b_num == '0) begin
                err   <= 1'b1;
                state <= S_FIN;
              end else begin
                state <= S_MN;
              end
            end else if (req.op == rfa_pkg::OP_RED) begin
              num_r <= DW'(req.a_num);
              den_r <= DW'(req.a_den);
              x     <= DW'(req.a_num);
              y     <= DW'(req.a_den);
              state <= S_GCD;
            end else begin
              err   <= 1'b1;
              state <= S_FIN;
            end
          end
        end
        S_MN: state <= S_MD;
        S_MD: begin
          num_r <= prod;
          state <= S_MX;
        end
        S_MX: begin
          den_r <= prod;
          x     <= num_r;
          y     <= prod;
          state <= S_GCD;
        end
        S_GCD: begin
          if (y == '0) begin
            if (x == '0) begin
              err   <= 1'b1;
              state <= S_FIN;
            end else begin
              state <= S_DIVN;
            end
          end else if (!dstat.busy) begin
            state <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (dstat.done) begin
            x     <= y;
            y     <= d_r;
            state <= S_GCD;
          end
        end
        S_DIVN: state <= S_DIVNW;
        S_DIVNW: begin
          if (dstat.done) begin
            q1    <= d_q;
            state <= S_DIVD;
          end
        end
        S_DIVD: state <= S_DIVDW;
        S_DIVDW: begin
          if (dstat.done) begin
            q2 <= d_q;
            if (op_r == rfa_pkg::OP_ADD) begin
              state <= S_T1;
            end else begin
              rn_r  <= q1;
              rd_r  <= d_q;
              state <= S_FIN;
            end
          end
        end
        S_T1: state <= S_T2;
        S_T2: begin
          acc   <= prod;
          state <= S_T3;
        end
        S_T3: begin
          acc   <= acc + prod;
          state <= S_T4;
        end
        S_T4: begin
          rn_r  <= acc;
          rd_r  <= prod;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rn_ext = EW'(rn_r);
  assign rd_ext = EW'(rd_r);

  // output register; a result beat may wait here while the next request runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || rsp.ready)) begin
      rsp.res_num <= err ? '0 : rn_ext[RW-1:0];
      rsp.res_den <= err ? '0 : rd_ext[RW-1:0];
      rsp.status  <= err;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// File: rtl/core/rfa_div.sv
// Bit-serial signed divider, truncating quotient, remainder takes dividend sign.
// Depends on rfa_pkg for the control and status structs.
module rfa_div #(
  parameter int DW = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  rfa_pkg::div_ctrl_t  ctrl,
  input  logic signed [DW-1:0] dividend,
  input  logic signed [DW-1:0] divisor,
  output rfa_pkg::div_stat_t  stat,
  output logic signed [DW-1:0] quo,
  output logic signed [DW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] qm;
  logic [DW-1:0] rm;
  logic [DW-1:0] dm;
  logic          sq;
  logic          sr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW-1:0] rsh;

  assign rsh = {rm[DW-2:0], qm[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      qm <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      dm <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
      rm <= '0;
      sq <= dividend[DW-1] ^ divisor[DW-1];
      sr <= dividend[DW-1];
    end else if (busy) begin
      if (rsh >= dm) begin
        rm <= rsh - dm;
        qm <= {qm[DW-2:0], 1'b1};
      end else begin
        rm <= rsh;
        qm <= {qm[DW-2:0], 1'b0};
      end
    end
  end

  assign quo = sq ? -$signed(qm) : $signed(qm);
  assign rem = sr ? -$signed(rm) : $signed(rm);

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: tb/tb.sv
// Self-checking testbench for rational_fraction_alu: directed table, then random fractions.
// Depends on rfa_pkg, rfa_req_if, rfa_rsp_if and the block itself; predicts random and untyped results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam int RW = rfa_pkg::RES_W;
  localparam int OPW = rfa_pkg::OP_W;
  localparam logic [rfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG = 20000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct {
    logic [rfa_pkg::OP_W-1:0] op;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
  } frac_req_t;

  typedef struct {
    logic signed [RW-1:0] num;
    logic signed [RW-1:0] den;
    logic status;
  } frac_result_t;

  typedef struct {
    frac_req_t req;
    bit typed;
    frac_result_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  rfa_req_if #(.W(W)) req();
  rfa_rsp_if rsp();

  rational_fraction_alu #(.OPERAND_WIDTH(W)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  frac_result_t pending_q[$];
  dir_row_t dir_tab[$];
  frac_result_t want;
  int mismatches = 0;
  int result_idx = 0;
  int idle_cycles = 0;
  bit send_calm = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Euclid with truncating remainder; sign follows the remainders
  function automatic longint frac_gcd(longint x, longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_frac(frac_req_t it);
    frac_result_t res;
    longint an, ad, bn, bd, g, l, n, d, rn, rd;
    bit err;
    an = it.a_num;
    ad = it.a_den;
    bn = it.b_num;
    bd = it.b_den;
    rn = 0;
    rd = 0;
    err = 1'b0;
    case (it.op)
      rfa_pkg::OP_ADD: begin
        if (ad == 0 || bd == 0) begin
          err = 1'b1;
        end else begin
          g = frac_gcd(ad, bd);
          l = (ad * bd) / g;
          rn = an * (l / ad) + bn * (l / bd);
          rd = l;
        end
      end
      rfa_pkg::OP_DIV: begin
        if (bn == 0) begin
          err = 1'b1;
        end else begin
          n = an * bd;
          d = ad * bn;
          g = frac_gcd(n, d);
          if (g == 0) begin
            err = 1'b1;
          end else begin
            rn = n / g;
            rd = d / g;
          end
        end
      end
      rfa_pkg::OP_RED: begin
        g = frac_gcd(an, ad);
        if (g == 0) begin
          err = 1'b1;
        end else begin
          rn = an / g;
          rd = ad / g;
        end
      end
      default: err = 1'b1;
    endcase
    if (err) begin
      rn = 0;
      rd = 0;
    end
    res.num = rn[RW-1:0];
    res.den = rd[RW-1:0];
    res.status = err;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic dir_row(input logic [rfa_pkg::OP_W-1:0] op, input int an, input int ad,
                         input int bn, input int bd, input bit typed = 0,
                         input longint en = 0, input longint ed = 0, input bit es = 0);
    dir_row_t r;
    r.req.op = op;
    r.req.a_num = an[W-1:0];
    r.req.a_den = ad[W-1:0];
    r.req.b_num = bn[W-1:0];
    r.req.b_den = bd[W-1:0];
    r.typed = typed;
    r.res.num = en[RW-1:0];
    r.res.den = ed[RW-1:0];
    r.res.status = es;
    dir_tab.push_back(r);
  endtask

  // mostly short gaps, a few long ones; none during calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [W-1:0] pick_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return 16'sd1;
        2: return -16'sd1;
        3: return 16'sh7fff;
        4: return 16'sh8000;
        default: return -16'sd2;
      endcase
    end
    if (r < 60) return W'(int'($urandom_range(0, 200)) - 100);
    return W'($urandom());
  endfunction

  function automatic frac_req_t rand_frac();
    frac_req_t it;
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 32) it.op = rfa_pkg::OP_ADD;
    else if (r < 64) it.op = rfa_pkg::OP_DIV;
    else if (r < 95) it.op = rfa_pkg::OP_RED;
    else it.op = OP_UNUSED;
    it.a_num = pick_operand();
    it.a_den = pick_operand();
    it.b_num = pick_operand();
    it.b_den = pick_operand();
    // shared factor so reduction has work to do
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(2, 200);
      it.a_num = W'(int'(it.a_num) * k);
      it.a_den = W'(int'(it.a_den) * k);
      it.b_num = W'(int'(it.b_num) * k);
      it.b_den = W'(int'(it.b_den) * k);
    end
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_frac(input frac_req_t it, input bit typed, input frac_result_t given);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      req.valid = 1'b0;
      req.op = OPW'($urandom());
      req.a_num = W'($urandom());
      req.a_den = W'($urandom());
      req.b_num = W'($urandom());
      req.b_den = W'($urandom());
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.op = it.op;
    req.a_num = it.a_num;
    req.a_den = it.a_den;
    req.b_num = it.b_num;
    req.b_den = it.b_den;
    do @(posedge clk); while (!req.ready);
    pending_q.push_back(typed ? given : predict_frac(it));
    @(negedge clk);
  endtask

  task automatic drain_results();
    req.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with nothing pending", result_idx));
      end else begin
        want = pending_q.pop_front();
        if (rsp.res_num !== want.num)
          flag_mismatch($sformatf("beat %0d res_num got %0d want %0d",
                                  result_idx, rsp.res_num, want.num));
        if (rsp.res_den !== want.den)
          flag_mismatch($sformatf("beat %0d res_den got %0d want %0d",
                                  result_idx, rsp.res_den, want.den));
        if (rsp.status !== want.status)
          flag_mismatch($sformatf("beat %0d status got %0b want %0b",
                                  result_idx, rsp.status, want.status));
      end
      result_idx++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("** rational_fraction_alu: FAILED **");
        $finish;
      end
    end
  end

  // receiver with random stalls and calm stretches
  initial begin
    int stall;
    int calm_left;
    bit calm;
    stall = 0;
    calm_left = 0;
    calm = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(200, 3000);
      end
      calm_left--;
      if (stall > 0) begin
        rsp.ready = 1'b0;
        stall--;
      end else begin
        rsp.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap(calm);
      end
    end
  end

  initial begin
    frac_result_t none;
    none.num = '0;
    none.den = '0;
    none.status = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = '0;
    req.a_num = '0;
    req.a_den = '0;
    req.b_num = '0;
    req.b_den = '0;

    dir_row(rfa_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0);
    dir_row(rfa_pkg::OP_ADD, 3, 0, 1, 2, 1, 0, 0, 1);        // zero a_den
    dir_row(rfa_pkg::OP_ADD, 1, 2, 3, 0, 1, 0, 0, 1);        // zero b_den
    dir_row(rfa_pkg::OP_DIV, 5, 7, 0, 3, 1, 0, 0, 1);        // divide by zero numerator
    dir_row(rfa_pkg::OP_DIV, 0, 0, 5, 4, 1, 0, 0, 1);        // both cross products zero
    dir_row(rfa_pkg::OP_RED, 0, 0, 32767, -32768, 1, 0, 0, 1);
    dir_row(rfa_pkg::OP_RED, 6, 0, -32768, 32767, 1, 1, 0, 0); // zero den kept
    dir_row(rfa_pkg::OP_DIV, 3, 0, 2, 5, 1, 1, 0, 0);
    dir_row(OP_UNUSED, -32768, 32767, -1, 1, 1, 0, 0, 1);
    dir_row(rfa_pkg::OP_RED, -32768, -32768, 0, 0, 1, 1, 1, 0);
    dir_row(rfa_pkg::OP_RED, 32767, -32768, 1, 1);
    dir_row(rfa_pkg::OP_ADD, -32768, 32767, 32767, -32768);
    dir_row(rfa_pkg::OP_ADD, -32768, -32768, -32768, -32768);
    dir_row(rfa_pkg::OP_ADD, 32767, 32767, 32767, 32767);
    dir_row(rfa_pkg::OP_DIV, -32768, -32768, -32768, -32768);
    dir_row(rfa_pkg::OP_DIV, 32767, 1, 1, 32767);
    dir_row(rfa_pkg::OP_DIV, -32768, 32767, 32767, -32768);
    dir_row(rfa_pkg::OP_RED, 12, -18, 0, 0);
    dir_row(rfa_pkg::OP_RED, -12, 18, 0, 0);
    dir_row(rfa_pkg::OP_RED, 0, 5, 7, 9);
    dir_row(rfa_pkg::OP_RED, -1, -1, -1, -1);
    dir_row(rfa_pkg::OP_ADD, -1, -1, 1, 1);
    dir_row(rfa_pkg::OP_ADD, 0, 1, 0, 1);
    dir_row(rfa_pkg::OP_DIV, 7, -1, -1, 1);
    dir_row(rfa_pkg::OP_DIV, 0, 3, 5, 7);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) send_frac(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 125 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_frac(rand_frac(), 1'b0, none);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("** rational_fraction_alu: PASSED **");
    end else begin
      $display("** rational_fraction_alu: FAILED **");
    end
    $finish;
  end

endmodule
